// ===== hdl/diff_drive_wheel_speeds_unit_macros.svh =====
// assertion macros shared by the wheel speed unit
`ifndef DIFF_DRIVE_WHEEL_SPEEDS_UNIT_MACROS_SVH
`define DIFF_DRIVE_WHEEL_SPEEDS_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DDWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define DDWS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DDWS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DDWS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/ddws_pkg.sv =====
package ddws_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_HALF_SPACING     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_WHEEL_RADIUS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND         = 2'd2;

    localparam logic [CFG_DATA_W-1:0] HALF_SPACING_RST     = 16'd0;
    localparam logic [CFG_DATA_W-1:0] INV_WHEEL_RADIUS_RST = 16'd2560;
    localparam logic [CFG_DATA_W-1:0] DEADBAND_RST         = 16'd7;

    // yaw source codes
    localparam logic [1:0] YAW_SRC_TURN_RATE = 2'd0;
    localparam logic [1:0] YAW_SRC_ATAN2     = 2'd1;
    localparam logic [1:0] YAW_SRC_ZERO      = 2'd2;

    // cordic
    localparam int CORDIC_ITERATIONS_DEF = 16;
    localparam int ATAN_ENTRIES          = 24;
    localparam int CX_W                  = 35;
    localparam int ANG_W                 = 20;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic [15:0] ATAN_Q16 [ATAN_ENTRIES] = '{
        16'd51472, 16'd30385, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2,
        16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
    };

    // command queue
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [23:0] linear_x;
        logic signed [23:0] linear_y;
        logic signed [23:0] angular_z;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] right_wheel_speed;
        logic signed [31:0] left_wheel_speed;
        logic [1:0]         yaw_source;
    } out_word_t;

    typedef struct packed {
        in_word_t   cmd;
        logic [1:0] src;
    } q_entry_t;

    typedef struct packed {
        logic                    valid;
        logic [1:0]              src;
        logic signed [23:0]      linear_x;
        logic signed [23:0]      angular_z;
        logic signed [CX_W-1:0]  cx;
        logic signed [CX_W-1:0]  cy;
        logic signed [ANG_W-1:0] ang;
    } cordic_stage_t;

endpackage

// ===== hdl/ddws_front.sv =====
module ddws_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ddws_pkg::in_word_t  s_data,
    input  logic [15:0]         deadband,
    output logic                push_valid,
    input  logic                push_ready,
    output ddws_pkg::q_entry_t  push_entry
);

    logic               hold_valid_reg;
    ddws_pkg::q_entry_t hold_reg;
    ddws_pkg::q_entry_t hold_next;
    logic signed [24:0] db;
    logic               z_out;
    logic               y_out;
    logic signed [24:0] z_ext;
    logic signed [24:0] y_ext;

    // deadband tests
    always_comb begin
        db    = signed'({9'b0, deadband});
        z_ext = 25'(s_data.angular_z);
        y_ext = 25'(s_data.linear_y);
        z_out = (z_ext > db) || (z_ext < -db);
        y_out = (y_ext > db) || (y_ext < -db);
    end

    // pick the yaw path
    always_comb begin
        hold_next.cmd = s_data;
        priority if (z_out) begin
            hold_next.src = ddws_pkg::YAW_SRC_TURN_RATE;
        end else if (y_out) begin
            hold_next.src = ddws_pkg::YAW_SRC_ATAN2;
        end else begin
            hold_next.src = ddws_pkg::YAW_SRC_ZERO;
        end
    end

    assign s_ready    = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_entry = hold_reg;

    // holding register ahead of the queue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            hold_reg <= hold_next;
        end
    end

endmodule

// ===== hdl/ddws_queue.sv =====
`include "diff_drive_wheel_speeds_unit_macros.svh"

module ddws_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  ddws_pkg::q_entry_t  push_entry,
    output logic                pop_valid,
    input  logic                pop_req,
    output ddws_pkg::q_entry_t  pop_entry
);

    localparam int DEPTH   = ddws_pkg::QUEUE_DEPTH;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    ddws_pkg::q_entry_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = (count_reg != COUNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_req && pop_valid;
    assign pop_entry  = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + 1'b1;
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and storage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `DDWS_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= COUNT_W'(DEPTH))
    `DDWS_ASSERT_NXT(a_push_only_grows, aclk, aresetn, push_fire && !pop_fire, count_reg == $past(count_reg) + 1'b1)
    `DDWS_ASSERT_NXT(a_pop_only_shrinks, aclk, aresetn, pop_fire && !push_fire, count_reg == $past(count_reg) - 1'b1)

endmodule

// ===== hdl/ddws_cordic.sv =====
module ddws_cordic #(
    parameter int ITERATIONS = ddws_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  ddws_pkg::q_entry_t      in_entry,
    output ddws_pkg::cordic_stage_t out_stage
);

    localparam int CX_W  = ddws_pkg::CX_W;
    localparam int ANG_W = ddws_pkg::ANG_W;

    ddws_pkg::cordic_stage_t st_reg [ITERATIONS+1];
    ddws_pkg::cordic_stage_t st0_next;
    logic signed [CX_W-1:0]  x_sc;
    logic signed [CX_W-1:0]  y_sc;

    // scale up by 2^8 and turn left half-plane vectors by a quarter turn
    always_comb begin
        x_sc = {{(CX_W-32){in_entry.cmd.linear_x[23]}}, in_entry.cmd.linear_x, 8'b0};
        y_sc = {{(CX_W-32){in_entry.cmd.linear_y[23]}}, in_entry.cmd.linear_y, 8'b0};
        st0_next.valid     = in_valid;
        st0_next.src       = in_entry.src;
        st0_next.linear_x  = in_entry.cmd.linear_x;
        st0_next.angular_z = in_entry.cmd.angular_z;
        st0_next.cx        = x_sc;
        st0_next.cy        = y_sc;
        st0_next.ang       = '0;
        if (x_sc < 0) begin
            if (y_sc >= 0) begin
                st0_next.cx  = y_sc;
                st0_next.cy  = -x_sc;
                st0_next.ang = ddws_pkg::HALF_PI_Q16;
            end else begin
                st0_next.cx  = -y_sc;
                st0_next.cy  = x_sc;
                st0_next.ang = -ddws_pkg::HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg[0].valid <= 1'b0;
        end else if (adv) begin
            st_reg[0] <= st0_next;
        end
    end

    // one vectoring step per stage
    for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
        ddws_pkg::cordic_stage_t  nxt;
        logic signed [CX_W-1:0]   cx_c;
        logic signed [CX_W-1:0]   cy_c;
        logic signed [CX_W-1:0]   dx;
        logic signed [CX_W-1:0]   dy;
        logic signed [ANG_W-1:0]  step;

        always_comb begin
            cx_c = st_reg[i].cx;
            cy_c = st_reg[i].cy;
            dx   = cy_c >>> i;
            dy   = cx_c >>> i;
            step = signed'({{(ANG_W-16){1'b0}}, ddws_pkg::ATAN_Q16[i]});
            nxt  = st_reg[i];
            if (cy_c > 0) begin
                nxt.cx  = cx_c + dx;
                nxt.cy  = cy_c - dy;
                nxt.ang = st_reg[i].ang + step;
            end else begin
                nxt.cx  = cx_c - dx;
                nxt.cy  = cy_c + dy;
                nxt.ang = st_reg[i].ang - step;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                st_reg[i+1].valid <= 1'b0;
            end else if (adv) begin
                st_reg[i+1] <= nxt;
            end
        end
    end

    assign out_stage = st_reg[ITERATIONS];

endmodule

// ===== hdl/ddws_wheel.sv =====
module ddws_wheel (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  ddws_pkg::cordic_stage_t in_stage,
    input  logic [15:0]             half_spacing,
    input  logic [15:0]             inv_wheel_radius,
    output logic                    adv,
    output logic                    m_valid,
    input  logic                    m_ready,
    output ddws_pkg::out_word_t     m_data
);

    // stage 1: yaw select and spacing product
    logic               v1_reg;
    logic [1:0]         src1_reg;
    logic signed [23:0] x1_reg;
    logic signed [40:0] prod1_reg;
    logic signed [23:0] yaw;
    logic signed [40:0] prod_next;

    // stage 2: side sums
    logic               v2_reg;
    logic [1:0]         src2_reg;
    logic signed [41:0] sr2_reg;
    logic signed [41:0] sl2_reg;
    logic signed [41:0] x_q;

    // stage 3: radius scaling
    logic               v3_reg;
    logic [1:0]         src3_reg;
    logic signed [58:0] wr3_reg;
    logic signed [58:0] wl3_reg;
    logic signed [16:0] inv_s;

    // output register
    logic                m_valid_reg;
    ddws_pkg::out_word_t m_data_reg;
    logic signed [58:0]  wr_rnd;
    logic signed [58:0]  wl_rnd;
    logic signed [34:0]  r_sh;
    logic signed [34:0]  l_sh;
    logic signed [31:0]  r_sat;
    logic signed [31:0]  l_sat;

    assign adv     = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // yaw by source
    always_comb begin
        unique case (in_stage.src)
            ddws_pkg::YAW_SRC_TURN_RATE: yaw = in_stage.angular_z;
            ddws_pkg::YAW_SRC_ATAN2:     yaw = 24'(in_stage.ang);
            default:                     yaw = '0;
        endcase
        prod_next = signed'({1'b0, half_spacing}) * yaw;
    end

    always_comb begin
        x_q   = {{2{x1_reg[23]}}, x1_reg, 16'b0};
        inv_s = signed'({1'b0, inv_wheel_radius});
    end

    // round to q16.16 and saturate
    always_comb begin
        wr_rnd = wr3_reg + 59'sd8388608;
        wl_rnd = wl3_reg + 59'sd8388608;
        r_sh   = wr_rnd[58:24];
        l_sh   = wl_rnd[58:24];
        if (r_sh[34:31] != {4{r_sh[34]}}) begin
            r_sat = r_sh[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            r_sat = r_sh[31:0];
        end
        if (l_sh[34:31] != {4{l_sh[34]}}) begin
            l_sat = l_sh[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else begin
            l_sat = l_sh[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg      <= in_stage.valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
        if (adv) begin
            src1_reg  <= in_stage.src;
            x1_reg    <= in_stage.linear_x;
            prod1_reg <= prod_next;
            src2_reg  <= src1_reg;
            sr2_reg   <= x_q + 42'(prod1_reg);
            sl2_reg   <= x_q - 42'(prod1_reg);
            src3_reg  <= src2_reg;
            wr3_reg   <= sr2_reg * inv_s;
            wl3_reg   <= sl2_reg * inv_s;
            m_data_reg.right_wheel_speed <= r_sat;
            m_data_reg.left_wheel_speed  <= l_sat;
            m_data_reg.yaw_source        <= src3_reg;
        end
    end

endmodule

// ===== hdl/diff_drive_wheel_speeds_unit.sv =====
// path: front holding register, queue, cordic stage registers, wheel stages and output register
// throughput: one word per cycle; the cordic and wheel stages advance together
// whenever the output register is empty or being taken, a 4-word queue absorbs stalls
// reset (aresetn low, synchronous): all valid flags clear, registers return to
// half_spacing 0, inv_wheel_radius 2560, deadband 7
`include "diff_drive_wheel_speeds_unit_macros.svh"

module diff_drive_wheel_speeds_unit #(
    parameter int CORDIC_ITERATIONS = ddws_pkg::CORDIC_ITERATIONS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ddws_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ddws_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ddws_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ddws_pkg::out_word_t                 m_data
);

    logic [15:0] half_spacing_reg;
    logic [15:0] inv_wheel_radius_reg;
    logic [15:0] deadband_reg;

    logic                    push_valid;
    logic                    push_ready;
    ddws_pkg::q_entry_t      push_entry;
    logic                    pop_valid;
    ddws_pkg::q_entry_t      pop_entry;
    logic                    adv;
    ddws_pkg::cordic_stage_t cordic_out;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_spacing_reg     <= ddws_pkg::HALF_SPACING_RST;
            inv_wheel_radius_reg <= ddws_pkg::INV_WHEEL_RADIUS_RST;
            deadband_reg         <= ddws_pkg::DEADBAND_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                ddws_pkg::REG_HALF_SPACING:     half_spacing_reg     <= cfg_wr_data;
                ddws_pkg::REG_INV_WHEEL_RADIUS: inv_wheel_radius_reg <= cfg_wr_data;
                ddws_pkg::REG_DEADBAND:         deadband_reg         <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // accept and classify
    ddws_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .deadband   (deadband_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // decoupling queue
    ddws_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_req    (adv),
        .pop_entry  (pop_entry)
    );

    // atan2 pipeline
    ddws_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (pop_valid),
        .in_entry  (pop_entry),
        .out_stage (cordic_out)
    );

    // wheel math and output register
    ddws_wheel u_wheel (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_stage         (cordic_out),
        .half_spacing     (half_spacing_reg),
        .inv_wheel_radius (inv_wheel_radius_reg),
        .adv              (adv),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

    `DDWS_ASSERT_IMP(a_zero_yaw_equal, aclk, aresetn, m_valid && (m_data.yaw_source == ddws_pkg::YAW_SRC_ZERO), m_data.right_wheel_speed == m_data.left_wheel_speed)

endmodule

// ===== tb/diff_drive_wheel_speeds_unit_tb.sv =====
module diff_drive_wheel_speeds_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddws_pkg::*;

    localparam int     HEADING_STEPS = 16;
    localparam int     PRE_SHIFT     = 8;
    localparam longint QUARTER_TURN  = 102944;
    localparam longint SPEED_MAX     = 64'sd2147483647;
    localparam longint SPEED_MIN     = -SPEED_MAX - 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    // arctangent table, Q16 radians
    localparam longint ARC_Q16 [24] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2,
        1, 0, 0, 0, 0, 0, 0, 0
    };

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;
    logic                   s_valid;
    logic                   s_ready;
    in_word_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_word_t              m_data;

    // register copies used for prediction
    longint spacing_cfg;
    longint inv_radius_cfg;
    longint band_cfg;

    in_word_t  cmd_q[$];
    out_word_t speeds_q[$];

    int  errors;
    int  cmds_taken;
    int  speeds_seen;
    int  src_tally [3];
    int  settings_used;
    int  hold_cycles;
    bit  steady;

    diff_drive_wheel_speeds_unit #(
        .CORDIC_ITERATIONS(HEADING_STEPS)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // clock
    always #5 aclk = ~aclk;

    // deadband test
    function automatic bit beyond_band(longint v);
        return v > band_cfg || v < -band_cfg;
    endfunction

    // vectoring cordic heading of (x, y), Q8.16 result
    function automatic longint cordic_heading(longint y, longint x);
        longint cx;
        longint cy;
        longint ang;
        longint t;
        longint dx;
        longint dy;
        cx  = x <<< PRE_SHIFT;
        cy  = y <<< PRE_SHIFT;
        ang = 0;
        if (cx < 0) begin
            t = cx;
            if (cy >= 0) begin
                cx  = cy;
                cy  = -t;
                ang = QUARTER_TURN;
            end else begin
                cx  = -cy;
                cy  = t;
                ang = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < HEADING_STEPS && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cy > 0) begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + ARC_Q16[i];
            end else begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - ARC_Q16[i];
            end
        end
        return ang;
    endfunction

    // one wheel: (x +/- spacing*yaw) * inverse radius, rounded and saturated
    function automatic logic signed [31:0] wheel_rate(longint x, longint yaw, bit plus);
        longint prod;
        longint sum;
        longint r;
        prod = spacing_cfg * yaw;
        sum  = (x <<< 16) + (plus ? prod : -prod);
        r    = (sum * inv_radius_cfg + (longint'(1) <<< 23)) >>> 24;
        if (r > SPEED_MAX) r = SPEED_MAX;
        if (r < SPEED_MIN) r = SPEED_MIN;
        return r[31:0];
    endfunction

    // expected wheel speeds for one command
    function automatic out_word_t wheel_speeds(in_word_t cmd);
        longint    x;
        longint    y;
        longint    z;
        longint    yaw;
        out_word_t res;
        x = cmd.linear_x;
        y = cmd.linear_y;
        z = cmd.angular_z;
        if (beyond_band(z)) begin
            yaw            = z;
            res.yaw_source = YAW_SRC_TURN_RATE;
        end else if (beyond_band(y)) begin
            yaw            = cordic_heading(y, x);
            res.yaw_source = YAW_SRC_ATAN2;
        end else begin
            yaw            = 0;
            res.yaw_source = YAW_SRC_ZERO;
        end
        res.right_wheel_speed = wheel_rate(x, yaw, 1'b1);
        res.left_wheel_speed  = wheel_rate(x, yaw, 1'b0);
        return res;
    endfunction

    task automatic note_mismatch(string what, longint got, longint want);
        $display("mismatch at result %0d, %0s: got %0d, expected %0d",
                 speeds_seen, what, got, want);
        errors++;
    endtask

    // sender: takes commands from the pending queue
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                speeds_q.push_back(wheel_speeds(s_data));
                cmds_taken++;
            end
            if (!s_valid || s_ready) begin
                if (cmd_q.size() > 0 && (steady || $urandom_range(99) >= 37)) begin
                    s_valid <= 1'b1;
                    s_data  <= cmd_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks each word against the oldest prediction
    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (speeds_q.size() == 0) begin
                    note_mismatch("word with nothing expected", m_data.right_wheel_speed, 0);
                end else begin
                    want = speeds_q.pop_front();
                    if (m_data.right_wheel_speed !== want.right_wheel_speed)
                        note_mismatch("right_wheel_speed", m_data.right_wheel_speed,
                                      want.right_wheel_speed);
                    if (m_data.left_wheel_speed !== want.left_wheel_speed)
                        note_mismatch("left_wheel_speed", m_data.left_wheel_speed,
                                      want.left_wheel_speed);
                    if (m_data.yaw_source !== want.yaw_source)
                        note_mismatch("yaw_source", m_data.yaw_source, want.yaw_source);
                    if (want.yaw_source <= YAW_SRC_ZERO)
                        src_tally[want.yaw_source]++;
                end
                speeds_seen++;
            end
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 37);
            end
        end
    end

    // register write, mirrored into the prediction copies
    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        case (idx)
            REG_HALF_SPACING:     spacing_cfg    = val;
            REG_INV_WHEEL_RADIUS: inv_radius_cfg = val;
            REG_DEADBAND:         band_cfg       = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until no command is pending and every word has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (cmd_q.size() > 0 || s_valid || speeds_q.size() > 0)
            @(negedge aclk);
    endtask

    task automatic setup(logic [15:0] spacing, logic [15:0] inv_r, logic [15:0] band);
        wait_drained();
        cfg_write(REG_HALF_SPACING, spacing);
        cfg_write(REG_INV_WHEEL_RADIUS, inv_r);
        cfg_write(REG_DEADBAND, band);
        settings_used++;
        @(negedge aclk);
    endtask

    task automatic push_cmd(int x, int y, int z);
        in_word_t cmd;
        cmd.linear_x  = x[23:0];
        cmd.linear_y  = y[23:0];
        cmd.angular_z = z[23:0];
        cmd_q.push_back(cmd);
    endtask

    // one field value: full range, inside the deadband, or at its edge
    function automatic int pick_field(bit want_in_band);
        int b;
        b = band_cfg;
        if (want_in_band)
            return int'($urandom_range(2 * b)) - b;
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? b + 1 : -b - 1;
            1:       return $urandom_range(1) ? 8388607 : -8388608;
            2:       return int'($urandom_range(131071)) - 65536;
            default: return int'($urandom() & 32'hFFFFFF);
        endcase
    endfunction

    task automatic push_random(int n);
        int  x;
        int  y;
        int  z;
        bit  z_in;
        bit  y_in;
        for (int i = 0; i < n; i++) begin
            z_in = $urandom_range(2) != 0;
            y_in = $urandom_range(3) == 0;
            x = $urandom_range(3) == 0 ? pick_field(0) : int'($urandom() & 32'hFFFFFF);
            z = z_in ? pick_field(1) : pick_field(0);
            y = y_in ? pick_field(1) : pick_field(0);
            push_cmd(x, y, z);
        end
    endtask

    // stimulus
    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = REG_HALF_SPACING;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        errors      = 0;
        hold_cycles = 0;
        steady      = 1'b0;
        spacing_cfg    = HALF_SPACING_RST;
        inv_radius_cfg = INV_WHEEL_RADIUS_RST;
        band_cfg       = DEADBAND_RST;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // write the unused index, which has no register; setup then rewrites all three
        cfg_write(REG_SPARE, 16'hFFFF);
        setup(16'h4000, INV_WHEEL_RADIUS_RST, DEADBAND_RST);

        // directed: field extremes, deadband edges, every yaw path and quadrant
        push_cmd(8388607, 0, 8388607);
        push_cmd(-8388608, 0, -8388608);
        push_cmd(65536, 0, 8);
        push_cmd(65536, 0, 7);
        push_cmd(65536, 0, -7);
        push_cmd(65536, 0, -8);
        push_cmd(65536, 8, 0);
        push_cmd(65536, -8, 0);
        push_cmd(65536, 7, 0);
        push_cmd(65536, -7, 3);
        push_cmd(-65536, 32768, 0);
        push_cmd(-65536, -32768, 0);
        push_cmd(0, 65536, 0);
        push_cmd(0, -65536, 0);
        push_cmd(-8388608, 8388607, 0);
        push_cmd(-8388608, -8388608, 0);
        push_cmd(8388607, 8388607, 0);
        push_cmd(8388607, -8388608, -7);
        push_cmd(0, 0, 0);
        push_cmd(8388607, 0, 0);
        push_cmd(-8388608, 0, 0);
        push_cmd(-1, 8, 0);
        push_cmd(-8388608, 0, 8388607);

        // random phases over several register settings
        setup(16'h4000, 16'd2560, 16'd7);
        push_random(180);

        // largest values; receiver holds off so the input backs up
        setup(16'hFFFF, 16'hFFFF, 16'h0000);
        push_random(180);
        hold_cycles = 300;

        // zero spacing and radius, widest deadband
        setup(16'h0000, 16'h0000, 16'hFFFF);
        push_random(150);

        // no idling on either side
        setup($urandom_range(65535), $urandom_range(65535), $urandom_range(255));
        steady = 1'b1;
        push_random(200);

        setup($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        steady = 1'b0;
        push_random(200);

        setup(16'h8000, 16'd256, 16'd1);
        push_random(180);

        wait_drained();
        repeat (30) @(posedge aclk);

        $display("covered %0d commands under %0d register settings", cmds_taken,
                 settings_used);
        $display("yaw from turn rate %0d, from heading %0d, zero %0d",
                 src_tally[0], src_tally[1], src_tally[2]);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("timeout with %0d words outstanding", speeds_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
